>>> rtl/core/cssim_pkg.sv
package cssim_pkg;

  localparam int SUM_W      = 44;
  localparam int ROOT_W     = 30;
  localparam int PROD_W     = 2 * ROOT_W;
  localparam int SIM_W      = 17;
  localparam int MUL_STEPS  = 16;
  localparam int PMUL_STEPS = ROOT_W;
  // 44 dividend bits followed by 32 fraction zeros
  localparam int DIV_STEPS  = SUM_W + 32;

  localparam logic [31:0]      ROOT_MAGIC   = 32'h1fbd1df5;
  localparam logic [SIM_W-1:0] SIM_MAX      = 17'h1ffff;
  localparam logic [5:0]       NORM_TOP     = 6'd43;
  localparam logic [7:0]       EXP_BIAS     = 8'd95;
  localparam logic [7:0]       ROOT_EXP_ONE = 8'd126;
  localparam logic [7:0]       ROOT_MAX_SH  = 8'd6;

endpackage

>>> rtl/core/cosine_similarity_stream.sv
// Per bin: 16 shift-add multiply steps and one accumulate step before the next
// bin is taken; one bin in flight at a time.
// Last bin: the result comes after the normalize shift, the 30-step root
// multiply and the 76-step divider; a zero norm sum skips all three, and a zero
// root product skips the divider. Output register holds one result.
// Synchronous active-high reset empties the output and clears all three sums.
module cosine_similarity_stream (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] hist_value,
  input  logic [15:0] model_value,
  input  logic        last_bin,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] similarity,
  output logic        zero_norm
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL  = 4'd1;
  localparam logic [3:0] ST_ACC  = 4'd2;
  localparam logic [3:0] ST_NORM = 4'd3;
  localparam logic [3:0] ST_ROOT = 4'd4;
  localparam logic [3:0] ST_PMUL = 4'd5;
  localparam logic [3:0] ST_DCHK = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  localparam int SW = cssim_pkg::SUM_W;
  localparam int RW = cssim_pkg::ROOT_W;
  localparam int PW = cssim_pkg::PROD_W;

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] acc, input logic [31:0] v);
    logic [SW:0] s;
    s = {1'b0, acc} + (SW+1)'(v);
    return s[SW] ? '1 : s[SW-1:0];
  endfunction

  // float encode, magic-constant root, decode to Q6.24
  function automatic logic [RW-1:0] root_decode(input logic [5:0] p, input logic [22:0] mant);
    logic [30:0]   fbits;
    logic [31:0]   r;
    logic [7:0]    er;
    logic [23:0]   sig;
    logic [7:0]    d;
    logic [RW-1:0] res;
    fbits = {8'({2'b00, p}) + cssim_pkg::EXP_BIAS, mant};
    r     = {2'b00, fbits[30:1]} + cssim_pkg::ROOT_MAGIC;
    er    = r[30:23];
    sig   = {1'b1, r[22:0]};
    if (er >= cssim_pkg::ROOT_EXP_ONE) begin
      d = er - cssim_pkg::ROOT_EXP_ONE;
      if (d > cssim_pkg::ROOT_MAX_SH) begin
        d = cssim_pkg::ROOT_MAX_SH;
      end
      res = RW'(sig) << d[2:0];
    end else begin
      d = cssim_pkg::ROOT_EXP_ONE - er;
      if (d >= 8'd32) begin
        res = '0;
      end else begin
        res = RW'(sig >> d[4:0]);
      end
    end
    return res;
  endfunction

  logic [3:0]  state;
  logic [6:0]  cnt;
  logic        last_q;

  logic [31:0] h_sh, m_sh;
  logic [15:0] hb, mb;
  logic [31:0] p_hm, p_hh, p_mm;

  logic [SW-1:0] dot_sum, norm_hist_sum, norm_model_sum;
  logic [SW-1:0] dot_next, nh_sum_next, nm_sum_next;

  logic [SW-1:0] nh, nm, dv;
  logic [5:0]    ph, pm;
  logic          nh_done, nm_done;

  logic [PW-1:0] pa, prod, rem;
  logic [RW-1:0] pb;

  logic [PW:0]   div_t;
  logic          div_ge;
  logic [PW:0]   div_diff;
  logic [17:0]   q_shift;

  logic [16:0] q;
  logic        sat;
  logic        zn;
  logic        out_load;

  assign in_stall = (state != ST_IDLE);
  assign out_load = (state == ST_OUT) && (!out_valid || !out_stall);

  assign dot_next    = sat_add(dot_sum, p_hm);
  assign nh_sum_next = sat_add(norm_hist_sum, p_hh);
  assign nm_sum_next = sat_add(norm_model_sum, p_mm);

  assign nh_done = nh[SW-1] || (ph == '0);
  assign nm_done = nm[SW-1] || (pm == '0);

  // restoring divide step; rem stays below prod so PW bits hold it
  assign div_t    = {rem, dv[SW-1]};
  assign div_ge   = (div_t >= {1'b0, prod});
  assign div_diff = div_t - {1'b0, prod};
  assign q_shift  = {q, div_ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      dot_sum        <= '0;
      norm_hist_sum  <= '0;
      norm_model_sum <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (cnt == 7'(cssim_pkg::MUL_STEPS - 1)) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (!last_q) begin
            dot_sum        <= dot_next;
            norm_hist_sum  <= nh_sum_next;
            norm_model_sum <= nm_sum_next;
            state          <= ST_IDLE;
          end else begin
            dot_sum        <= '0;
            norm_hist_sum  <= '0;
            norm_model_sum <= '0;
            if (nh_sum_next == '0 || nm_sum_next == '0) begin
              state <= ST_OUT;
            end else begin
              state <= ST_NORM;
            end
          end
        end
        ST_NORM: begin
          if (nh_done && nm_done) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          state <= ST_PMUL;
        end
        ST_PMUL: begin
          if (cnt == 7'(cssim_pkg::PMUL_STEPS - 1)) begin
            state <= ST_DCHK;
          end
        end
        ST_DCHK: begin
          state <= (prod == '0) ? ST_OUT : ST_DIV;
        end
        ST_DIV: begin
          if (cnt == 7'(cssim_pkg::DIV_STEPS - 1)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      similarity <= sat ? cssim_pkg::SIM_MAX : q;
      zero_norm  <= zn;
    end

    case (state)
      ST_IDLE: begin
        h_sh   <= {16'd0, hist_value};
        m_sh   <= {16'd0, model_value};
        hb     <= hist_value;
        mb     <= model_value;
        p_hm   <= '0;
        p_hh   <= '0;
        p_mm   <= '0;
        cnt    <= '0;
        last_q <= last_bin;
      end
      ST_MUL: begin
        if (mb[0]) begin
          p_hm <= p_hm + h_sh;
          p_mm <= p_mm + m_sh;
        end
        if (hb[0]) begin
          p_hh <= p_hh + h_sh;
        end
        h_sh <= {h_sh[30:0], 1'b0};
        m_sh <= {m_sh[30:0], 1'b0};
        hb   <= {1'b0, hb[15:1]};
        mb   <= {1'b0, mb[15:1]};
        cnt  <= cnt + 7'd1;
      end
      ST_ACC: begin
        nh  <= nh_sum_next;
        nm  <= nm_sum_next;
        dv  <= dot_next;
        ph  <= cssim_pkg::NORM_TOP;
        pm  <= cssim_pkg::NORM_TOP;
        q   <= '0;
        sat <= 1'b0;
        zn  <= (nh_sum_next == '0 || nm_sum_next == '0);
      end
      ST_NORM: begin
        if (!nh_done) begin
          nh <= {nh[SW-2:0], 1'b0};
          ph <= ph - 6'd1;
        end
        if (!nm_done) begin
          nm <= {nm[SW-2:0], 1'b0};
          pm <= pm - 6'd1;
        end
      end
      ST_ROOT: begin
        pa   <= PW'(root_decode(ph, nh[SW-2:SW-24]));
        pb   <= root_decode(pm, nm[SW-2:SW-24]);
        prod <= '0;
        cnt  <= '0;
      end
      ST_PMUL: begin
        if (pb[0]) begin
          prod <= prod + pa;
        end
        pa  <= {pa[PW-2:0], 1'b0};
        pb  <= {1'b0, pb[RW-1:1]};
        cnt <= cnt + 7'd1;
      end
      ST_DCHK: begin
        rem <= '0;
        cnt <= '0;
        zn  <= (prod == '0);
      end
      ST_DIV: begin
        rem <= div_ge ? div_diff[PW-1:0] : div_t[PW-1:0];
        dv  <= {dv[SW-2:0], 1'b0};
        cnt <= cnt + 7'd1;
        if (q_shift[17]) begin
          q   <= cssim_pkg::SIM_MAX;
          sat <= 1'b1;
        end else begin
          q <= q_shift[16:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/cssim_checker.sv
module cssim_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [16:0] similarity,
  input logic        zero_norm
);

  // held result must not move while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(similarity) && $stable(zero_norm))
    else $error("output transaction changed while stalled");

  a_zero_norm_sim: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_norm |-> similarity == 17'd0)
    else $error("zero norm with nonzero similarity");

  // one bin in flight: busy right after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous bin in flight");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind cosine_similarity_stream cssim_checker u_cssim_checker (.*);

>>> bench/cosine_similarity_stream_tb.sv
typedef struct packed {
  logic [16:0] similarity;
  logic        zero_norm;
} cos_result_t;

class cosine_scoreboard;
  localparam logic [31:0] SQRT_MAGIC = 32'h1fbd1df5;
  localparam logic [16:0] SIM_CEIL   = 17'h1ffff;

  logic [43:0] dot_acc;
  logic [43:0] hist_energy;
  logic [43:0] model_energy;
  cos_result_t pending[$];
  int          errors;

  function new();
    dot_acc      = '0;
    hist_energy  = '0;
    model_energy = '0;
    errors       = 0;
  endfunction

  static function logic [43:0] sat_accumulate(logic [43:0] acc, logic [31:0] term);
    logic [44:0] total;
    total = {1'b0, acc} + {13'b0, term};
    return total[44] ? '1 : total[43:0];
  endfunction

  // float encode, magic root, decode to Q6.24
  static function logic [63:0] approx_root_q6_24(logic [43:0] energy);
    int          lead;
    int          sh;
    logic [63:0] wide;
    logic [22:0] mant;
    logic [31:0] fbits;
    logic [31:0] rbits;
    logic [63:0] sig;
    lead = 43;
    while (lead > 0 && !energy[lead]) lead--;
    wide = {20'b0, energy};
    if (lead >= 23) mant = 23'(wide >> (lead - 23));
    else mant = 23'(wide << (23 - lead));
    fbits = (32'(lead + 95) << 23) | {9'b0, mant};
    rbits = (fbits >> 1) + SQRT_MAGIC;
    sig   = {40'b0, 1'b1, rbits[22:0]};
    sh    = int'(rbits[30:23]) - 126;
    if (sh >= 0) return sig << ((sh > 6) ? 6 : sh);
    if (-sh >= 32) return '0;
    return sig >> (-sh);
  endfunction

  function void note_bin(logic [15:0] h, logic [15:0] m, logic last);
    cos_result_t res;
    logic [63:0] prod;
    logic [75:0] quo;
    dot_acc      = sat_accumulate(dot_acc, 32'(h) * 32'(m));
    hist_energy  = sat_accumulate(hist_energy, 32'(h) * 32'(h));
    model_energy = sat_accumulate(model_energy, 32'(m) * 32'(m));
    if (!last) return;
    res = '0;
    if (hist_energy == 0 || model_energy == 0) begin
      res.zero_norm = 1'b1;
    end else begin
      prod = approx_root_q6_24(hist_energy) * approx_root_q6_24(model_energy);
      if (prod == 0) begin
        res.zero_norm = 1'b1;
      end else begin
        quo = {dot_acc, 32'b0} / {12'b0, prod};
        res.similarity = (quo > 76'(SIM_CEIL)) ? SIM_CEIL : quo[16:0];
      end
    end
    pending.push_back(res);
    dot_acc      = '0;
    hist_energy  = '0;
    model_energy = '0;
  endfunction

  function void check_result(logic [16:0] sim, logic zn);
    cos_result_t exp_res;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result similarity=%0d zero_norm=%0d", $time, sim, zn);
      errors++;
      return;
    end
    exp_res = pending.pop_front();
    if (sim !== exp_res.similarity) begin
      $display("%0t: similarity mismatch expected %0d actual %0d",
               $time, exp_res.similarity, sim);
      errors++;
    end
    if (zn !== exp_res.zero_norm) begin
      $display("%0t: zero_norm mismatch expected %0d actual %0d",
               $time, exp_res.zero_norm, zn);
      errors++;
    end
  endfunction
endclass

module cosine_similarity_stream_tb;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] hist_value = '0;
  logic [15:0] model_value = '0;
  logic        last_bin = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [16:0] similarity;
  logic        zero_norm;

  cosine_scoreboard sb = new();

  int snd_idle = 7;
  int rcv_idle = 72;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  cosine_similarity_stream i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .hist_value(hist_value),
    .model_value(model_value),
    .last_bin(last_bin),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .similarity(similarity),
    .zero_norm(zero_norm)
  );

  always #4 clk = ~clk;

  // receiver: random stall, or a long hold when requested
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < rcv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(similarity, zero_norm);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_bin(input logic [15:0] h, input logic [15:0] m, input logic last);
    while ($urandom_range(99) < snd_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    hist_value  = h;
    model_value = m;
    last_bin    = last;
    do @(posedge clk); while (in_stall);
    sb.note_bin(h, m, last);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_value(int kind);
    case (kind)
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(3));
      2: return 16'h0000;
      3: return 16'hffff;
      default: return pick_value($urandom_range(3));
    endcase
  endfunction

  function automatic int pick_kind();
    int roll;
    roll = $urandom_range(9);
    if (roll < 5) return 0;
    if (roll < 8) return roll - 4;
    return 4;
  endfunction

  task automatic send_vector(output int len);
    int h_kind;
    int m_kind;
    h_kind = pick_kind();
    m_kind = pick_kind();
    // mostly short vectors, now and then a longer one
    len = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
    for (int i = 0; i < len; i++) begin
      send_bin(pick_value(h_kind), pick_value(m_kind), i == len - 1);
    end
  endtask

  task automatic send_random(int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      send_vector(len);
      sent += len;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    snd_idle = 7;
    rcv_idle = 72;
    // single-bin vectors: both norms zero, one norm zero, extremes
    send_bin(16'h0000, 16'h0000, 1'b1);
    send_bin(16'hffff, 16'h0000, 1'b1);
    send_bin(16'h0000, 16'hffff, 1'b1);
    send_bin(16'hffff, 16'hffff, 1'b1);
    send_bin(16'h0001, 16'h0001, 1'b1);
    send_bin(16'h0001, 16'hffff, 1'b1);
    // nearly orthogonal, then a four-bin mixed vector
    send_bin(16'hffff, 16'h0001, 1'b0);
    send_bin(16'h0001, 16'hffff, 1'b1);
    send_bin(16'haaaa, 16'h5555, 1'b0);
    send_bin(16'h5555, 16'haaaa, 1'b0);
    send_bin(16'hffff, 16'hffff, 1'b0);
    send_bin(16'h8000, 16'h0001, 1'b1);
    // zero dot, nonzero norms; then a vector ending in zero bins
    send_bin(16'h0000, 16'h0005, 1'b0);
    send_bin(16'h0007, 16'h0000, 1'b1);
    send_bin(16'h0003, 16'h0003, 1'b0);
    send_bin(16'h0000, 16'h0000, 1'b0);
    send_bin(16'h0000, 16'h0000, 1'b1);
    send_random(360);

    snd_idle = 72;
    rcv_idle = 7;
    send_random(360);

    snd_idle = 0;
    rcv_idle = 0;
    // a long run of full-scale bins
    for (int i = 0; i < 100; i++) send_bin(16'hffff, 16'hffff, i == 99);
    hold_req = 1'b1;
    send_random(360);
    in_valid = 1'b0;
    last_bin = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
